// File: design/cedl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cedl_pkg
// Shared types, register indexes and helpers of the cascaded echo delay.
// ----------------------------------------------------------------------------
package cedl_pkg;

	localparam int TAP_W  = 3;
	localparam int ACC_W  = 36;
	localparam int PROD_W = 53;
	localparam int SHIFT  = 27;

	typedef enum logic [2:0] {
		REG_IN_GAIN     = 3'd0,
		REG_POST_GAIN   = 3'd1,
		REG_TAP_COUNT   = 3'd2,
		REG_DELAYS_LOW  = 3'd3,
		REG_DELAYS_HIGH = 3'd4,
		REG_DECAYS_LOW  = 3'd5,
		REG_DECAYS_HIGH = 3'd6,
		REG_ENABLE      = 3'd7
	} reg_idx_t;

	typedef enum logic [10:0] {
		S_RST   = 11'b000_0000_0001,
		S_INIT  = 11'b000_0000_0010,
		S_CLEAR = 11'b000_0000_0100,
		S_IDLE  = 11'b000_0000_1000,
		S_ACC   = 11'b000_0001_0000,
		S_READ  = 11'b000_0010_0000,
		S_SCALE = 11'b000_0100_0000,
		S_ROUND = 11'b000_1000_0000,
		S_WRITE = 11'b001_0000_0000,
		S_STEP  = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic [15:0] in_gain;
		logic [15:0] post_gain;
		logic [2:0]  tap_count;
		logic [63:0] delays_low;
		logic [47:0] delays_high;
		logic [63:0] decays_low;
		logic [47:0] decays_high;
		logic        enable;
	} cfg_t;

	typedef struct packed {
		logic             restart;
		logic             base_load;
		logic             base_reduce;
		logic             clr_write;
		logic             take;
		logic             acc_init;
		logic             rd_issue;
		logic             acc_add;
		logic             scale;
		logic             round;
		logic             wr_slot;
		logic             step;
		logic             out_load;
		logic [TAP_W-1:0] tap;
		logic [TAP_W-1:0] acc_tap;
		logic [TAP_W-1:0] n;
	} cmd_t;

	typedef struct packed {
		logic sum_ge;
		logic clr_last;
	} sts_t;

	// Picks the 16-bit field of one stage out of the low and high words.
	function automatic logic [15:0] field16(logic [63:0] lo, logic [47:0] hi,
			logic [TAP_W-1:0] j);
		logic [15:0] r;
		unique case (j)
			3'd0: r = lo[15:0];
			3'd1: r = lo[31:16];
			3'd2: r = lo[47:32];
			3'd3: r = lo[63:48];
			3'd4: r = hi[15:0];
			3'd5: r = hi[31:16];
			3'd6: r = hi[47:32];
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/cedl_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cedl_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module cedl_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [5:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output cedl_pkg::cfg_t   cfg,
	output logic             restart
);
	import cedl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[5:3]);
	assign wr  = psel && penable && pwrite;
	assign restart = wr && (idx == REG_TAP_COUNT || idx == REG_DELAYS_LOW ||
		idx == REG_DELAYS_HIGH);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_gain     <= 16'd32768;
			cfg_q.post_gain   <= 16'd4096;
			cfg_q.tap_count   <= 3'd0;
			cfg_q.delays_low  <= '0;
			cfg_q.delays_high <= '0;
			cfg_q.decays_low  <= '0;
			cfg_q.decays_high <= '0;
			cfg_q.enable      <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_IN_GAIN:     cfg_q.in_gain     <= pwdata[15:0];
				REG_POST_GAIN:   cfg_q.post_gain   <= pwdata[15:0];
				REG_TAP_COUNT:   cfg_q.tap_count   <= pwdata[2:0];
				REG_DELAYS_LOW:  cfg_q.delays_low  <= pwdata;
				REG_DELAYS_HIGH: cfg_q.delays_high <= pwdata[47:0];
				REG_DECAYS_LOW:  cfg_q.decays_low  <= pwdata;
				REG_DECAYS_HIGH: cfg_q.decays_high <= pwdata[47:0];
				REG_ENABLE:      cfg_q.enable      <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_IN_GAIN:     prdata = {48'd0, cfg_q.in_gain};
			REG_POST_GAIN:   prdata = {48'd0, cfg_q.post_gain};
			REG_TAP_COUNT:   prdata = {61'd0, cfg_q.tap_count};
			REG_DELAYS_LOW:  prdata = cfg_q.delays_low;
			REG_DELAYS_HIGH: prdata = {16'd0, cfg_q.delays_high};
			REG_DECAYS_LOW:  prdata = cfg_q.decays_low;
			REG_DECAYS_HIGH: prdata = {16'd0, cfg_q.decays_high};
			REG_ENABLE:      prdata = {63'd0, cfg_q.enable};
		endcase
	end

endmodule
`default_nettype wire

// File: design/cedl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cedl_dp
// Datapath: delay memory, stage slot counters, accumulator and output scaling.
// ----------------------------------------------------------------------------
module cedl_dp #(
	parameter int MAX_TAPS    = 7,
	parameter int MEM_DEPTH   = 65536,
	parameter int MAX_TAP_LEN = 8192
) (
	input  logic               clk,
	input  cedl_pkg::cfg_t     cfg,
	input  cedl_pkg::cmd_t     cmd,
	output cedl_pkg::sts_t     sts,
	input  logic signed [15:0] sample_in,
	output logic signed [15:0] sample_out
);
	import cedl_pkg::*;

	localparam int AW  = $clog2(MEM_DEPTH);
	localparam int PW  = (MAX_TAP_LEN > 1) ? $clog2(MAX_TAP_LEN) : 1;
	localparam int LW  = $clog2(MAX_TAP_LEN + 1);
	localparam int SW  = $clog2(MEM_DEPTH + MAX_TAP_LEN + 1);
	localparam int TIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [15:0]              mem [MEM_DEPTH];
	logic [SW-1:0]            sum_q;
	logic [AW-1:0]            clr_q;
	logic [AW-1:0]            bm_q [MAX_TAPS];
	logic [AW-1:0]            slot_q [MAX_TAPS];
	logic [PW-1:0]            pos_q [MAX_TAPS];
	logic [LW-1:0]            len_w [MAX_TAPS];
	logic signed [15:0]       x_q, v_q, res_q, out_q;
	logic signed [15:0]       rdata_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [TIW-1:0]           tix;
	logic [15:0]              raw;
	logic signed [32:0]       p_in, p_dec;
	logic signed [PROD_W-1:0] p_out;
	logic [PROD_W-1:0]        mag;
	logic [PROD_W-SHIFT-1:0]  q;
	logic [15:0]              rnd;
	logic signed [16:0]       vsum;
	logic [15:0]              vnext;
	logic                     mem_we;
	logic [AW-1:0]            wa;
	logic [15:0]              wd;

	assign tix = cmd.tap[TIW-1:0];

	always_comb begin
		raw = 16'd0;
		for (int i = 0; i < MAX_TAPS; i++) begin
			raw = field16(cfg.delays_low, cfg.delays_high, TAP_W'(i));
			if (raw == 16'd0)
				len_w[i] = LW'(1);
			else if ({1'b0, raw} > 17'(MAX_TAP_LEN))
				len_w[i] = LW'(MAX_TAP_LEN);
			else
				len_w[i] = LW'(raw);
		end
	end

	assign p_in  = $signed({1'b0, cfg.in_gain}) * x_q;
	assign p_dec = $signed({1'b0, field16(cfg.decays_low, cfg.decays_high, cmd.acc_tap)})
		* rdata_q;
	assign p_out = acc_q * $signed({1'b0, cfg.post_gain});

	always_comb begin
		mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		q   = mag[PROD_W-1:SHIFT];
		if (!prod_q[PROD_W-1])
			rnd = (q > (PROD_W-SHIFT)'(32767)) ? 16'h7fff : q[15:0];
		else
			rnd = (q > (PROD_W-SHIFT)'(32768)) ? 16'h8000 : 16'(16'd0 - q[15:0]);
	end

	assign vsum  = 17'(v_q) + 17'(x_q);
	assign vnext = (vsum[16] != vsum[15]) ? (vsum[16] ? 16'h8000 : 16'h7fff) : vsum[15:0];

	assign sts.sum_ge   = sum_q >= SW'(MEM_DEPTH);
	assign sts.clr_last = clr_q == AW'(MEM_DEPTH - 1);

	assign mem_we = cmd.clr_write || cmd.wr_slot;
	assign wa     = cmd.clr_write ? clr_q : slot_q[tix];
	assign wd     = cmd.clr_write ? 16'd0 : v_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wa] <= wd;
		if (cmd.rd_issue)
			rdata_q <= mem[slot_q[tix]];
	end

	always_ff @(posedge clk) begin
		if (cmd.restart) begin
			sum_q <= '0;
			clr_q <= '0;
		end else if (cmd.base_load) begin
			sum_q <= sum_q + SW'(len_w[tix]);
		end else if (cmd.base_reduce) begin
			sum_q <= sum_q - SW'(MEM_DEPTH);
		end
		if (cmd.clr_write)
			clr_q <= clr_q + AW'(1);
		if (cmd.base_load) begin
			bm_q[tix]   <= sum_q[AW-1:0];
			slot_q[tix] <= sum_q[AW-1:0];
			pos_q[tix]  <= '0;
		end
		if (cmd.step) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				if (TAP_W'(i) < cmd.n) begin
					if (LW'(pos_q[i]) + LW'(1) == len_w[i]) begin
						pos_q[i]  <= '0;
						slot_q[i] <= bm_q[i];
					end else begin
						pos_q[i]  <= pos_q[i] + PW'(1);
						if ((AW+1)'(slot_q[i]) + (AW+1)'(1) == (AW+1)'(MEM_DEPTH))
							slot_q[i] <= '0;
						else
							slot_q[i] <= slot_q[i] + AW'(1);
					end
				end
			end
		end
		if (cmd.take) begin
			x_q   <= sample_in;
			res_q <= sample_in;
		end
		if (cmd.acc_init)
			acc_q <= ACC_W'(p_in);
		else if (cmd.acc_add)
			acc_q <= acc_q + ACC_W'(p_dec);
		if (cmd.scale)
			prod_q <= p_out;
		if (cmd.round) begin
			res_q <= rnd;
			v_q   <= x_q;
		end else if (cmd.wr_slot) begin
			v_q <= vnext;
		end
		if (cmd.out_load)
			out_q <= res_q;
	end

	assign sample_out = out_q;

endmodule
`default_nettype wire

// File: design/cedl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cedl_ctrl
// Controller: line restart, memory clearing and the per-sample sequence.
// ----------------------------------------------------------------------------
module cedl_ctrl #(
	parameter int MAX_TAPS = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cedl_pkg::cfg_t cfg,
	input  logic           restart,
	input  cedl_pkg::sts_t sts,
	output cedl_pkg::cmd_t cmd,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready
);
	import cedl_pkg::*;

	state_t           state_q, state_d;
	logic [TAP_W-1:0] j_q, j_d, n;
	logic             out_valid_q;

	assign n = (cfg.tap_count > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : cfg.tap_count;
	assign in_ready  = (state_q == S_IDLE) && !restart;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.n       = n;
		cmd.tap     = j_q;
		cmd.acc_tap = j_q - TAP_W'(1);
		state_d     = state_q;
		j_d         = j_q;
		unique case (state_q)
			S_RST: begin
				cmd.restart = 1'b1;
				j_d         = '0;
				state_d     = S_INIT;
			end
			S_INIT: begin
				if (sts.sum_ge) begin
					cmd.base_reduce = 1'b1;
				end else begin
					cmd.base_load = 1'b1;
					if (j_q == TAP_W'(MAX_TAPS - 1))
						state_d = S_CLEAR;
					else
						j_d = j_q + TAP_W'(1);
				end
			end
			S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.take = 1'b1;
					j_d      = '0;
					state_d  = cfg.enable ? S_ACC : S_OUT;
				end
			end
			S_ACC: begin
				cmd.acc_init = 1'b1;
				state_d      = S_READ;
			end
			S_READ: begin
				cmd.rd_issue = j_q < n;
				cmd.acc_add  = j_q != '0;
				if (j_q == n)
					state_d = S_SCALE;
				else
					j_d = j_q + TAP_W'(1);
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				j_d       = '0;
				state_d   = (n == '0) ? S_STEP : S_WRITE;
			end
			S_WRITE: begin
				cmd.wr_slot = 1'b1;
				if (j_q == n - TAP_W'(1))
					state_d = S_STEP;
				else
					j_d = j_q + TAP_W'(1);
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_RST;
		endcase
		if (restart)
			state_d = S_RST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RST;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> j_q <= n)
		else $error("tap index ran past the stage count");
	a_take_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_ACC || state_q == S_OUT))
		else $error("accepted sample did not start processing");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> state_q == S_RST)
		else $error("line restart was not taken");
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !cmd.out_load) |=> !out_valid)
		else $error("output stayed valid after its transfer");

endmodule
`default_nettype wire

// File: design/cascaded_echo_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_echo_delay
// Multi-stage echo over one shared delay memory, one sample in, one sample out.
// ----------------------------------------------------------------------------
// Samples enter on the in_valid/in_ready channel and leave on the
// out_valid/out_ready channel, one result transfer for each input transfer.
// Registers are written through the APB-style port at byte address 8*index.
// With echo enabled and n stages in use, a sample passes from its transfer
// through S_ACC, S_READ, S_SCALE, S_ROUND, S_WRITE, S_STEP and S_OUT before
// the next sample is taken; the delay memory is read once per stage in
// S_READ and written once per stage in S_WRITE. With echo disabled a sample
// goes straight to S_OUT, which loads the result into the output register.
// After reset, and after any write to tap_count, delays_low or delays_high,
// the stage bases are recomputed, each wrapped below MEM_DEPTH, and the
// delay memory is cleared one word a cycle; no sample is taken meanwhile.
// The result sits in an output register; a new sample is taken while it
// waits, and a stalled receiver holds the block before its next result.
// ----------------------------------------------------------------------------
module cascaded_echo_delay #(
	parameter int MAX_TAPS    = 7,
	parameter int MEM_DEPTH   = 65536,
	parameter int MAX_TAP_LEN = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out
);
	import cedl_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic restart;

	assign pready = 1'b1;

	cedl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.restart (restart)
	);

	cedl_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.restart   (restart),
		.sts       (sts),
		.cmd       (cmd),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	cedl_dp #(
		.MAX_TAPS    (MAX_TAPS),
		.MEM_DEPTH   (MEM_DEPTH),
		.MAX_TAP_LEN (MAX_TAP_LEN)
	) u_dp (
		.clk        (clk),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule
`default_nettype wire
